// File: rtl/core/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg
// Shared types and constants of the clamped PID controller.
// ----------------------------------------------------------------------------
package pidc_pkg;

   localparam int unsigned DATA_W  = 16;
   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic {
      ACT_UPDATE = 1'b0,
      ACT_PEEK   = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP    = 2'd0,
      CSR_KI    = 2'd1,
      CSR_KD    = 2'd2,
      CSR_LIMIT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0]  kp;
      logic [DATA_W-1:0]  ki;
      logic [DATA_W-1:0]  kd;
      logic [LIMIT_W-1:0] limit;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] error_sum;
      logic [DATA_W-1:0] last_pv;
   } state_type;

endpackage

// File: rtl/core/pidc_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_req_if
// Input channel: action, set point and measured value.
// ----------------------------------------------------------------------------
interface pidc_req_if;
   logic                              valid;
   logic                              ready;
   pidc_pkg::action_type              action;
   logic signed [pidc_pkg::DATA_W-1:0] set_point;
   logic signed [pidc_pkg::DATA_W-1:0] process_value;

   modport source (output valid, action, set_point, process_value, input ready);
   modport sink   (input valid, action, set_point, process_value, output ready);
endinterface

// File: rtl/core/pidc_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_rsp_if
// Result channel: controller drive.
// ----------------------------------------------------------------------------
interface pidc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [pidc_pkg::DATA_W-1:0] drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

// File: rtl/core/pidc_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_csr_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface pidc_csr_if;
   logic                              valid;
   logic                              ready;
   pidc_pkg::csr_index_type           index;
   logic [pidc_pkg::DATA_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/pidc_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_datapath
// Error clamp, sum update and the three gain products for one sample.
// ----------------------------------------------------------------------------
module pidc_datapath (
   input  pidc_pkg::cfg_type                cfg,
   input  pidc_pkg::state_type              state,
   input  pidc_pkg::action_type             action,
   input  logic [pidc_pkg::DATA_W-1:0]      set_point,
   input  logic [pidc_pkg::DATA_W-1:0]      process_value,
   output logic [pidc_pkg::DATA_W-1:0]      drive,
   output logic [pidc_pkg::DATA_W-1:0]      error_sum_next
);
   import pidc_pkg::*;

   function automatic logic [DATA_W-1:0] clamp_to_limit(
      input logic signed [DATA_W:0]  v,
      input logic [LIMIT_W-1:0]      lim
   );
      logic signed [DATA_W:0] hi;
      logic signed [DATA_W:0] lo;
      logic signed [DATA_W:0] r;
      hi = signed'({2'b00, lim});
      lo = -hi;
      if (v > hi) begin
         r = hi;
      end else if (v < lo) begin
         r = lo;
      end else begin
         r = v;
      end
      return r[DATA_W-1:0];
   endfunction

   logic [DATA_W-1:0]      err_wrap;
   logic [DATA_W-1:0]      err_clamped;
   logic signed [DATA_W:0] sum_wide;
   logic [DATA_W-1:0]      sum_clamped;
   logic [DATA_W-1:0]      sum_used;
   logic [DATA_W-1:0]      pv_delta;
   logic [2*DATA_W-1:0]    p_full;
   logic [2*DATA_W-1:0]    i_full;
   logic [2*DATA_W-1:0]    d_full;

   assign err_wrap    = set_point - process_value;
   assign err_clamped = clamp_to_limit(signed'({err_wrap[DATA_W-1], err_wrap}), cfg.limit);

   assign sum_wide    = signed'({state.error_sum[DATA_W-1], state.error_sum})
                      + signed'({err_clamped[DATA_W-1], err_clamped});
   assign sum_clamped = clamp_to_limit(sum_wide, cfg.limit);
   assign sum_used    = (action == ACT_UPDATE) ? sum_clamped : state.error_sum;

   assign pv_delta = process_value - state.last_pv;

   assign p_full = cfg.kp * err_clamped;
   assign i_full = cfg.ki * sum_used;
   assign d_full = cfg.kd * pv_delta;

   assign drive          = p_full[DATA_W-1:0] + i_full[DATA_W-1:0] + d_full[DATA_W-1:0];
   assign error_sum_next = sum_used;

endmodule

// File: rtl/core/pid_controller_clamped.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped
// PID controller with clamped error and clamped integral, one sample a clock unless the result is stalled.
// ----------------------------------------------------------------------------
// Every accepted sample gives exactly one drive value. A sample is taken into
// an input register; the whole controller step (error clamp, sum update, three
// 16x16 products, final add) runs combinationally between that register and the
// result register, so a new sample can be taken every clock while the result
// channel is not stalled. For update actions, integral and last-measurement
// state is written in the same cycle as the result, so back-to-back samples see
// it at once. Registers should be written only while the block is idle; the
// block itself does not enforce this. The write channel is always ready.
// ----------------------------------------------------------------------------
module pid_controller_clamped (
   input logic        clock,
   input logic        reset,
   pidc_req_if.sink   req_chan,
   pidc_rsp_if.source rsp_chan,
   pidc_csr_if.sink   csr_chan
);
   import pidc_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   state_type         state_ff, state_in;
   logic              in_valid_ff, in_valid_in;
   action_type        in_action_ff;
   logic [DATA_W-1:0] in_sp_ff;
   logic [DATA_W-1:0] in_pv_ff;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_drive_ff;

   logic              advance;
   logic              req_take;
   logic              fire;
   logic [DATA_W-1:0] drive_calc;
   logic [DATA_W-1:0] sum_next;

   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_take = req_chan.valid && req_chan.ready;
   assign fire     = in_valid_ff && advance;

   assign req_chan.ready = !in_valid_ff || advance;
   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.drive = out_drive_ff;
   assign csr_chan.ready = 1'b1;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_KP:    cfg_in.kp    = csr_chan.data;
            CSR_KI:    cfg_in.ki    = csr_chan.data;
            CSR_KD:    cfg_in.kd    = csr_chan.data;
            CSR_LIMIT: cfg_in.limit = csr_chan.data[LIMIT_W-1:0];
            default:   cfg_in       = cfg_ff;
         endcase
      end
   end

   pidc_datapath u_datapath (
      .cfg            (cfg_ff),
      .state          (state_ff),
      .action         (in_action_ff),
      .set_point      (in_sp_ff),
      .process_value  (in_pv_ff),
      .drive          (drive_calc),
      .error_sum_next (sum_next)
   );

   always_comb begin
      state_in = state_ff;
      if (fire && in_action_ff == ACT_UPDATE) begin
         state_in.error_sum = sum_next;
         state_in.last_pv   = in_pv_ff;
      end
   end

   assign in_valid_in  = req_chan.ready ? req_chan.valid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_chan.action;
         in_sp_ff     <= req_chan.set_point;
         in_pv_ff     <= req_chan.process_value;
      end
      if (fire) begin
         out_drive_ff <= drive_calc;
      end
   end

endmodule
